[design/ftc_pkg.sv]
// Shared types and constants of the floor texel coordinate block.
// Depends on nothing; every other file of the block but ftc_div imports it.
package ftc_pkg;

    localparam int COL_W   = 12;
    localparam int ROW_W   = 12;
    localparam int WEND_W  = 13;
    localparam int POS_W   = 22;
    localparam int DIST_W  = 24;
    localparam int DEN_W   = 12;
    localparam int TEX_W   = 6;
    localparam int CEIL_W  = 13;
    localparam int W_W     = 17;

    localparam int SCREEN_HEIGHT_DEF = 512;

    localparam logic [W_W-1:0]    ONE_Q16  = 17'h10000;
    localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

    // Classified pixel as it leaves the front stage.
    typedef struct packed {
        logic               vld;
        logic               hz;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [DEN_W-1:0]   den;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [POS_W-1:0]   wx;
        logic [POS_W-1:0]   wy;
        logic [DIST_W-1:0]  wd;
    } t_item;

endpackage

[design/ftc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Depends on nothing beyond its parameters.
module ftc_div #(
    parameter int NW = 16,
    parameter int DW = 24,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_occ,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_occ,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_occ  [NW+1];
    logic [NW-1:0] r_nq   [NW+1];
    logic [DW-1:0] r_rem  [NW+1];
    logic [DW-1:0] r_den  [NW+1];
    logic [SW-1:0] r_side [NW+1];

    assign r_occ[0]  = i_occ;
    assign r_nq[0]   = i_num;
    assign r_rem[0]  = i_rem;
    assign r_den[0]  = i_den;
    assign r_side[0] = i_side;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW:0] t;
        logic [DW:0] diff;
        logic        ge;

        assign t    = {r_rem[k], r_nq[k][NW-1]};
        assign diff = t - {1'b0, r_den[k]};
        assign ge   = (t >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_occ[k+1] <= 1'b0;
            end else if (i_en) begin
                r_occ[k+1] <= r_occ[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
                r_nq[k+1]   <= {r_nq[k][NW-2:0], ge};
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_occ  = r_occ[NW];
    assign o_quo  = r_nq[NW];
    assign o_side = r_side[NW];

endmodule

[design/ftc_front.sv]
// Front stage: accepts pixels and classifies them (span check, horizon, divisor).
// Depends on ftc_pkg.
module ftc_front #(
    parameter int SCREEN_HEIGHT = ftc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [ftc_pkg::COL_W-1:0]   i_column,
    input  logic [ftc_pkg::ROW_W-1:0]   i_row,
    input  logic [ftc_pkg::WEND_W-1:0]  i_wall_end_row,
    input  logic [ftc_pkg::POS_W-1:0]   i_player_x,
    input  logic [ftc_pkg::POS_W-1:0]   i_player_y,
    input  logic [ftc_pkg::POS_W-1:0]   i_wall_floor_x,
    input  logic [ftc_pkg::POS_W-1:0]   i_wall_floor_y,
    input  logic [ftc_pkg::DIST_W-1:0]  i_wall_distance,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output ftc_pkg::t_item              o_item
);
    import ftc_pkg::*;

    localparam logic [ROW_W:0] H = (ROW_W+1)'(SCREEN_HEIGHT);

    logic         r_valid, n_valid;
    t_item        r_item,  n_item;
    logic         accept;
    logic [ROW_W:0]   twice;
    logic [ROW_W+1:0] d;

    assign full     = r_valid && i_q_full;
    assign accept   = push && !full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_item   = r_item;

    always_comb begin
        twice  = {i_row, 1'b0};
        d      = {1'b0, twice} - {1'b0, H};
        n_item.vld    = !i_wall_end_row[WEND_W-1]
                        && (i_row > i_wall_end_row[ROW_W-1:0])
                        && ({1'b0, i_row} < H);
        n_item.hz     = (twice <= H);
        n_item.column = i_column;
        n_item.row    = i_row;
        n_item.den    = n_item.hz ? DEN_W'(1) : d[DEN_W-1:0];
        n_item.px     = i_player_x;
        n_item.py     = i_player_y;
        n_item.wx     = i_wall_floor_x;
        n_item.wy     = i_wall_floor_y;
        n_item.wd     = i_wall_distance;
        n_valid = accept ? 1'b1 : (o_q_push ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

[design/ftc_queue.sv]
// Two-entry queue between front and back stages.
// Depends on ftc_pkg.
module ftc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ftc_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output ftc_pkg::t_item  o_item
);
    import ftc_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_pop;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_item     = r_mem[r_rp];
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (do_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

[design/ftc_back.sv]
// Back stage: row distance divide, weight divide, blend and result register.
// Depends on ftc_pkg and ftc_div.
module ftc_back #(
    parameter int SCREEN_HEIGHT = ftc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ftc_pkg::DIST_W-1:0]  i_player_distance,
    input  logic                        i_q_nonempty,
    input  ftc_pkg::t_item              i_item,
    output logic                        o_q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_valid_res,
    output logic [ftc_pkg::COL_W-1:0]   o_column_out,
    output logic [ftc_pkg::ROW_W-1:0]   o_floor_row,
    output logic [ftc_pkg::CEIL_W-1:0]  o_ceiling_row,
    output logic [ftc_pkg::TEX_W-1:0]   o_texel_u,
    output logic [ftc_pkg::TEX_W-1:0]   o_texel_v
);
    import ftc_pkg::*;

    localparam int HW  = $clog2(SCREEN_HEIGHT + 1);
    localparam int NW1 = HW + 16;
    localparam int CW  = (NW1 > DIST_W + 1) ? NW1 : DIST_W + 1;
    localparam int IW  = $bits(t_item);
    localparam int PW  = W_W + POS_W;
    localparam int SUMW = PW + 1;

    localparam logic [1:0] MODE_QUO  = 2'd0;
    localparam logic [1:0] MODE_ZERO = 2'd1;
    localparam logic [1:0] MODE_ONE  = 2'd2;

    logic en;
    logic r_ov;

    assign en      = !r_ov || pop;
    assign empty   = !r_ov;
    assign o_q_pop = en;

    // Row distance divide
    logic             d1_occ;
    logic [NW1-1:0]   d1_quo;
    logic [IW-1:0]    d1_side;
    t_item            d1_item;
    logic [CW-1:0]    q1x;
    logic [DIST_W-1:0] cd;

    ftc_div #(.NW(NW1), .DW(DEN_W), .SW(IW)) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_occ   (i_q_nonempty),
        .i_num   (NW1'(SCREEN_HEIGHT) << 16),
        .i_rem   ('0),
        .i_den   (i_item.den),
        .i_side  (i_item),
        .o_occ   (d1_occ),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    assign d1_item = t_item'(d1_side);
    assign q1x     = CW'(d1_quo);
    assign cd      = (d1_item.hz || q1x > CW'(DIST_MAX)) ? DIST_MAX : q1x[DIST_W-1:0];

    // Numerator and divisor of the weight
    logic                       r2_occ;
    t_item                      r2_item;
    logic signed [DIST_W:0]     r2_num, r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_occ <= 1'b0;
        end else if (en) begin
            r2_occ <= d1_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_item <= d1_item;
            r2_num  <= $signed({1'b0, cd}) - $signed({1'b0, i_player_distance});
            r2_den  <= $signed({1'b0, d1_item.wd}) - $signed({1'b0, i_player_distance});
        end
    end

    // Classify the weight: clamped ends resolve here, the rest is divided
    logic [DIST_W:0]   an_x, ad_x;
    logic [DIST_W-1:0] an, ad;
    logic [1:0]        mode;

    always_comb begin
        an_x = r2_num[DIST_W] ? (DIST_W+1)'(-r2_num) : r2_num;
        ad_x = r2_den[DIST_W] ? (DIST_W+1)'(-r2_den) : r2_den;
        an   = an_x[DIST_W-1:0];
        ad   = ad_x[DIST_W-1:0];
        if (r2_den == '0) begin
            mode = MODE_ONE;
        end else if (r2_num == '0 || (r2_num[DIST_W] != r2_den[DIST_W])) begin
            mode = MODE_ZERO;
        end else if (an >= ad) begin
            mode = MODE_ONE;
        end else begin
            mode = MODE_QUO;
        end
    end

    logic              d2_occ;
    logic [15:0]       d2_quo;
    logic [IW+1:0]     d2_side;
    t_item             d2_item;
    logic [1:0]        d2_mode;

    ftc_div #(.NW(16), .DW(DIST_W), .SW(IW + 2)) u_div_wgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_occ   (r2_occ),
        .i_num   ('0),
        .i_rem   (an),
        .i_den   (ad),
        .i_side  ({mode, r2_item}),
        .o_occ   (d2_occ),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    assign d2_mode = d2_side[IW+1:IW];
    assign d2_item = t_item'(d2_side[IW-1:0]);

    // Blend products
    logic [W_W-1:0] w, wn;

    always_comb begin
        case (d2_mode)
            MODE_ONE:  w = ONE_Q16;
            MODE_ZERO: w = '0;
            default:   w = {1'b0, d2_quo};
        endcase
        wn = ONE_Q16 - w;
    end

    logic           r4_occ;
    t_item          r4_item;
    logic [PW-1:0]  r4_ax, r4_bx, r4_ay, r4_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_occ <= 1'b0;
        end else if (en) begin
            r4_occ <= d2_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_item <= d2_item;
            r4_ax   <= w  * d2_item.wx;
            r4_bx   <= wn * d2_item.px;
            r4_ay   <= w  * d2_item.wy;
            r4_by   <= wn * d2_item.py;
        end
    end

    // Result register
    logic [SUMW-1:0] sx, sy;

    assign sx = SUMW'(r4_ax) + SUMW'(r4_bx);
    assign sy = SUMW'(r4_ay) + SUMW'(r4_by);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r4_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_valid_res  <= r4_item.vld;
            o_column_out <= r4_item.column;
            if (r4_item.vld) begin
                o_floor_row   <= r4_item.row;
                o_ceiling_row <= CEIL_W'(SCREEN_HEIGHT) - CEIL_W'(r4_item.row);
                o_texel_u     <= sx[31:32-TEX_W];
                o_texel_v     <= sy[31:32-TEX_W];
            end else begin
                o_floor_row   <= '0;
                o_ceiling_row <= '0;
                o_texel_u     <= '0;
                o_texel_v     <= '0;
            end
        end
    end

endmodule

[design/floor_texel_coordinate.sv]
// Top level of the floor texel coordinate block: front, queue and back stages.
// Depends on ftc_pkg, ftc_front, ftc_queue, ftc_back (and ftc_div below it).
//
// One floor pixel enters per clock and one result leaves per clock while the
// consumer keeps popping. A pixel passes from push to the result ports through
// the front register, the queue, the one-bit-per-stage row distance divider,
// the weight numerator register, the 16-stage weight divider, the product
// register and the result register. The input side is a front register plus
// a two-entry queue, so pushes are still accepted after the result side stops
// popping; full rises once both are taken. Pixels outside the floor span come
// back with valid_res low and zero coordinates, the column still copied. Write
// player_distance only while no pixel is in flight.
module floor_texel_coordinate #(
    parameter int SCREEN_HEIGHT = ftc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [ftc_pkg::DIST_W-1:0]  i_cfg_wdata,
    input  logic                        push,
    output logic                        full,
    input  logic [ftc_pkg::COL_W-1:0]   i_column,
    input  logic [ftc_pkg::ROW_W-1:0]   i_row,
    input  logic [ftc_pkg::WEND_W-1:0]  i_wall_end_row,
    input  logic [ftc_pkg::POS_W-1:0]   i_player_x,
    input  logic [ftc_pkg::POS_W-1:0]   i_player_y,
    input  logic [ftc_pkg::POS_W-1:0]   i_wall_floor_x,
    input  logic [ftc_pkg::POS_W-1:0]   i_wall_floor_y,
    input  logic [ftc_pkg::DIST_W-1:0]  i_wall_distance,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_valid_res,
    output logic [ftc_pkg::COL_W-1:0]   o_column_out,
    output logic [ftc_pkg::ROW_W-1:0]   o_floor_row,
    output logic [ftc_pkg::CEIL_W-1:0]  o_ceiling_row,
    output logic [ftc_pkg::TEX_W-1:0]   o_texel_u,
    output logic [ftc_pkg::TEX_W-1:0]   o_texel_v
);
    import ftc_pkg::*;

    logic [DIST_W-1:0] r_player_distance;

    // Hold the player distance; it must be written only while idle, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_distance <= '0;
        end else if (i_cfg_wen) begin
            r_player_distance <= i_cfg_wdata;
        end
    end

    logic  q_full, q_push, q_pop, q_nonempty;
    t_item f_item, q_item;

    ftc_front #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_wall_end_row  (i_wall_end_row),
        .i_player_x      (i_player_x),
        .i_player_y      (i_player_y),
        .i_wall_floor_x  (i_wall_floor_x),
        .i_wall_floor_y  (i_wall_floor_y),
        .i_wall_distance (i_wall_distance),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_item          (f_item)
    );

    // Decouple classification from the long arithmetic pipeline.
    ftc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_item     (f_item),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_item     (q_item)
    );

    ftc_back #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_player_distance (r_player_distance),
        .i_q_nonempty      (q_nonempty),
        .i_item            (q_item),
        .o_q_pop           (q_pop),
        .empty             (empty),
        .pop               (pop),
        .o_valid_res       (o_valid_res),
        .o_column_out      (o_column_out),
        .o_floor_row       (o_floor_row),
        .o_ceiling_row     (o_ceiling_row),
        .o_texel_u         (o_texel_u),
        .o_texel_v         (o_texel_v)
    );

endmodule
